// ===== src/iq_linear_interp_resampler_unit_macros.svh =====
// Assertion macros used by the resampler checker.
// No dependencies; included by the checker file.
`ifndef IQ_LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`define IQ_LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH

// Consequent checked on the cycle after the antecedent.
`define IQLIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked on the same cycle as the antecedent.
`define IQLIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/iqlir_pkg.sv =====
// Package for the linear interpolation resampler: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps

package iqlir_pkg;

    localparam int unsigned SAMPLE_W      = 32;
    localparam int unsigned RAW_W         = 2 * SAMPLE_W;
    localparam int unsigned FRAC_W        = 11;
    localparam int unsigned IDX_W         = 11;
    localparam int unsigned OUTS_PER_BLOCK = 2048;
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(OUTS_PER_BLOCK - 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic              fire;
        logic [FRAC_W-1:0] frac;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_phase_info;

endpackage

// ===== src/iq_linear_interp_resampler_unit.sv =====
// Linear interpolation IQ resampler, IN_PER_BLOCK input samples to 2048 outputs.
// Top level; depends on iqlir_pkg, iqlir_phase and iqlir_lerp.
//
// Input channel: i_in_valid / o_in_ready carry one raw 64-bit IQ sample
// (bits 31:0 I, bits 63:32 Q, signed). Output channel: o_out_valid /
// i_out_ready carry interpolated I and Q (signed, input scale), the output's
// index within its 2048-sample block, and a flag on the block's last output.
// Config channel: i_cfg_valid / o_cfg_ready writes the I/Q swap bit; it is
// always ready and takes effect from the next sample.
// An input item produces zero or one output item. The first sample after
// reset only primes the previous-sample register.
// An input item that completes an output goes to the input stage register,
// then the multiply-add writes the result into the output register.
// Throughput: one input item per cycle while o_in_ready is high, with a
// combinational multiply-add per component between the two registers.
// Reset clears the swap bit, the block position, the phase and both
// pipeline valid bits. When the receiver stalls, the output register holds
// and the stage behind it fills; o_in_ready drops only when both are full.
`timescale 1ns / 1ps

module iq_linear_interp_resampler_unit
    import iqlir_pkg::*;
#(
    parameter int unsigned IN_PER_BLOCK = 3072
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [RAW_W-1:0]  i_sample_bytes,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_sample           o_out_i,
    output t_sample           o_out_q,
    output logic [IDX_W-1:0]  o_out_index,
    output logic              o_block_last
);

    logic              r_swap;
    t_sample           r_prev_i, r_prev_q;

    logic              r_s1_valid;
    t_sample           r_s1_prev_i, r_s1_prev_q, r_s1_cur_i, r_s1_cur_q;
    logic [FRAC_W-1:0] r_s1_frac;
    logic [IDX_W-1:0]  r_s1_index;
    logic              r_s1_last;

    logic              r_out_valid;
    t_sample           r_out_i, r_out_q;
    logic [IDX_W-1:0]  r_out_index;
    logic              r_out_last;

    t_sample           cur_i, cur_q, lerp_i, lerp_q;
    logic              in_accept, out_free, s1_take;
    t_phase_info       phase;

    assign o_cfg_ready = 1'b1;
    assign cur_i       = r_swap ? i_sample_bytes[RAW_W-1:SAMPLE_W] : i_sample_bytes[SAMPLE_W-1:0];
    assign cur_q       = r_swap ? i_sample_bytes[SAMPLE_W-1:0] : i_sample_bytes[RAW_W-1:SAMPLE_W];
    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_take     = !r_s1_valid || out_free;
    assign o_in_ready  = s1_take;
    assign in_accept   = i_in_valid && s1_take;

    iqlir_phase #(
        .IN_PER_BLOCK(IN_PER_BLOCK)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .o_info   (phase)
    );

    iqlir_lerp u_lerp_i (
        .i_a    (r_s1_prev_i),
        .i_b    (r_s1_cur_i),
        .i_frac (r_s1_frac),
        .o_y    (lerp_i)
    );

    iqlir_lerp u_lerp_q (
        .i_a    (r_s1_prev_q),
        .i_b    (r_s1_cur_q),
        .i_frac (r_s1_frac),
        .o_y    (lerp_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_swap <= i_cfg_data;
            end
            if (s1_take) begin
                r_s1_valid <= in_accept && phase.fire;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_prev_i <= cur_i;
            r_prev_q <= cur_q;
        end
        if (in_accept && phase.fire) begin
            r_s1_prev_i <= r_prev_i;
            r_s1_prev_q <= r_prev_q;
            r_s1_cur_i  <= cur_i;
            r_s1_cur_q  <= cur_q;
            r_s1_frac   <= phase.frac;
            r_s1_index  <= phase.index;
            r_s1_last   <= phase.last;
        end
        if (r_s1_valid && out_free) begin
            r_out_i     <= lerp_i;
            r_out_q     <= lerp_q;
            r_out_index <= r_s1_index;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_i      = r_out_i;
    assign o_out_q      = r_out_q;
    assign o_out_index  = r_out_index;
    assign o_block_last = r_out_last;

endmodule

// ===== src/iqlir_phase.sv =====
// Block position and output phase tracking of the resampler.
// Depends on iqlir_pkg.
`timescale 1ns / 1ps

module iqlir_phase
    import iqlir_pkg::*;
#(
    parameter int unsigned IN_PER_BLOCK = 3072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    output t_phase_info o_info
);

    localparam int unsigned POS_W  = $clog2(IN_PER_BLOCK + 1);
    localparam int unsigned BASE_W = $clog2(IN_PER_BLOCK);
    localparam int unsigned ACC_W  = FRAC_W + BASE_W;
    localparam logic [POS_W-1:0] POS_END  = POS_W'(IN_PER_BLOCK);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [ACC_W-1:0] ACC_STEP = ACC_W'(IN_PER_BLOCK);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [IDX_W-1:0] r_next, n_next;

    logic [POS_W-1:0] base_p1;
    logic             hit;
    logic             last;

    always_comb begin
        base_p1 = POS_W'(r_acc[ACC_W-1:FRAC_W]) + POS_ONE;
        hit     = (r_pos != '0) && (base_p1 == r_pos);
        last    = (r_next == LAST_INDEX);

        o_info.fire  = hit;
        o_info.frac  = r_acc[FRAC_W-1:0];
        o_info.index = r_next;
        o_info.last  = last;

        n_pos  = r_pos;
        n_acc  = r_acc;
        n_next = r_next;
        if (i_accept) begin
            if (r_pos == '0 || r_pos >= POS_END) begin
                n_pos = POS_ONE;
            end else begin
                n_pos = r_pos + POS_ONE;
            end
            if (hit) begin
                if (last) begin
                    n_acc  = '0;
                    n_next = '0;
                end else begin
                    n_acc  = r_acc + ACC_STEP;
                    n_next = r_next + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_next <= '0;
        end else begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_next <= n_next;
        end
    end

endmodule

// ===== src/iqlir_lerp.sv =====
// One-component linear interpolation: floor((a*(2048-f) + b*f) / 2048).
// Depends on iqlir_pkg.
`timescale 1ns / 1ps

module iqlir_lerp
    import iqlir_pkg::*;
(
    input  t_sample           i_a,
    input  t_sample           i_b,
    input  logic [FRAC_W-1:0] i_frac,
    output t_sample           o_y
);

    localparam int unsigned DIFF_W = SAMPLE_W + 1;
    localparam int unsigned PROD_W = DIFF_W + FRAC_W + 1;
    localparam int unsigned SUM_W  = SAMPLE_W + 2;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        diff = DIFF_W'(i_b) - DIFF_W'(i_a);
        prod = diff * $signed({1'b0, i_frac});
        sum  = SUM_W'(i_a) + $signed(prod[PROD_W-1:FRAC_W]);
        o_y  = sum[SAMPLE_W-1:0];
    end

endmodule

// ===== src/iqlir_checker.sv =====
// Port-level checker for the resampler, bound to the top level.
// Depends on iqlir_pkg and iq_linear_interp_resampler_unit_macros.svh.
`timescale 1ns / 1ps
`include "iq_linear_interp_resampler_unit_macros.svh"

module iqlir_checker
    import iqlir_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic              i_cfg_data,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [RAW_W-1:0]  i_sample_bytes,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_sample           o_out_i,
    input t_sample           o_out_q,
    input logic [IDX_W-1:0]  o_out_index,
    input logic              o_block_last
);

    `IQLIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_i) && $stable(o_out_q) && $stable(o_out_index), "stalled output item changed")
    `IQLIR_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, o_out_valid, o_block_last == (o_out_index == LAST_INDEX), "block_last does not match final index")
    `IQLIR_ASSERT_NEXT(a_index_seq, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_block_last, !o_out_valid || (o_out_index == IDX_W'($past(o_out_index) + 1'b1)), "output index skipped")
    `IQLIR_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 2), "output item without input item")

endmodule

bind iq_linear_interp_resampler_unit iqlir_checker u_iqlir_checker (.*);
